// File: src/eel_pkg.sv
// shared constants, op codes and control/status types for the encoder event logger
package eel_pkg;

  // record ring geometry
  localparam int RING_DEPTH = 512;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  // field widths
  localparam int OP_W   = 2;
  localparam int TIME_W = 32;
  localparam int POS_W  = 32;
  localparam int STEP_W = 2;

  // stream widths
  localparam int IN_TDATA_W   = 40;
  localparam int IN_TUSER_W   = OP_W;
  localparam int OUT_TDATA_W  = 104;
  localparam int OUT_TUSER_W  = 3;

  // op codes carried in tuser
  localparam logic [OP_W-1:0] OP_EDGE1 = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE2 = 2'd1;
  localparam logic [OP_W-1:0] OP_POP   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // step codes
  localparam logic [STEP_W-1:0] STEP_ZERO = 2'b00;
  localparam logic [STEP_W-1:0] STEP_UP   = 2'b01;
  localparam logic [STEP_W-1:0] STEP_DOWN = 2'b11;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic finish;    // execute edge / empty pop / no-op and load the result
    logic rd_issue;  // start the registered ring read
    logic pop_done;  // load the popped record and advance the read pointer
  } eel_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_read;  // held op is a pop and the ring holds a record
    logic out_free;  // output register can take a result this cycle
  } eel_stat_t;

endpackage

// File: src/eel_ctrl.sv
// controller state machine sequencing capture, execute and ring read
module eel_ctrl
  import eel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  eel_stat_t stat,
  output eel_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POPW
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_tready_nxt = in_tready_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.capture   = 1'b1;
          state_nxt     = ST_EXEC;
          in_tready_nxt = 1'b0;
        end
      end
      ST_EXEC: begin
        if (stat.pop_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_POPW;
        end else if (stat.out_free) begin
          cmd.finish    = 1'b1;
          state_nxt     = ST_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      ST_POPW: begin
        if (stat.out_free) begin
          cmd.pop_done  = 1'b1;
          state_nxt     = ST_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        in_tready_nxt = 1'b1;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;

endmodule

// File: src/eel_dp.sv
// datapath: positions, record ring, pointers and output register
module eel_dp
  import eel_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  eel_cmd_t               cmd,
  output eel_stat_t              stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  // configuration
  logic enable_r;

  // captured transaction
  logic [OP_W-1:0]   op_r;
  logic              phase_r;
  logic [TIME_W-1:0] time_r;

  // encoder positions and ring pointers
  logic [POS_W-1:0] first_cnt_r, first_cnt_nxt;
  logic [POS_W-1:0] second_cnt_r, second_cnt_nxt;
  logic [PTR_W-1:0] wr_idx_r, rd_idx_r, wr_inc, rd_inc;

  // ring storage and registered read data
  logic [TIME_W-1:0]         time_mem [RING_DEPTH];
  logic [2*POS_W-1:0]        pos_mem  [RING_DEPTH];
  logic [2*STEP_W-1:0]       step_mem [RING_DEPTH];
  logic [TIME_W-1:0]         rd_time_r;
  logic [2*POS_W-1:0]        rd_pos_r;
  logic [2*STEP_W-1:0]       rd_step_r;

  // result fields
  logic              res_acc, res_drop, res_popv;
  logic [TIME_W-1:0] res_time;
  logic [POS_W-1:0]  res_fpos, res_spos;
  logic [STEP_W-1:0] res_fstep, res_sstep, step_code;
  logic              is_edge, full, push;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  assign wr_inc    = (wr_idx_r == PTR_LAST) ? '0 : wr_idx_r + 1'b1;
  assign rd_inc    = (rd_idx_r == PTR_LAST) ? '0 : rd_idx_r + 1'b1;
  assign full      = (wr_inc == rd_idx_r);
  assign is_edge   = ((op_r == OP_EDGE1) || (op_r == OP_EDGE2)) && enable_r;
  assign step_code = phase_r ? STEP_DOWN : STEP_UP;
  assign push      = cmd.finish && is_edge && !full;

  assign stat.pop_read = (op_r == OP_POP) && (rd_idx_r != wr_idx_r);
  assign stat.out_free = !out_valid_r || out_tready;

  // position step for the held edge
  always_comb begin
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    if (op_r == OP_EDGE1) begin
      first_cnt_nxt = phase_r ? first_cnt_r - 1'b1 : first_cnt_r + 1'b1;
    end else begin
      second_cnt_nxt = phase_r ? second_cnt_r - 1'b1 : second_cnt_r + 1'b1;
    end
  end

  // result selection
  always_comb begin
    res_acc   = 1'b0;
    res_drop  = 1'b0;
    res_popv  = 1'b0;
    res_time  = '0;
    res_fpos  = '0;
    res_spos  = '0;
    res_fstep = STEP_ZERO;
    res_sstep = STEP_ZERO;
    if (cmd.pop_done) begin
      res_popv  = 1'b1;
      res_time  = rd_time_r;
      res_fpos  = rd_pos_r[POS_W-1:0];
      res_spos  = rd_pos_r[2*POS_W-1:POS_W];
      res_fstep = rd_step_r[STEP_W-1:0];
      res_sstep = rd_step_r[2*STEP_W-1:STEP_W];
    end else if (is_edge) begin
      res_acc   = 1'b1;
      res_drop  = full;
      res_time  = time_r;
      res_fpos  = first_cnt_nxt;
      res_spos  = second_cnt_nxt;
      res_fstep = (op_r == OP_EDGE1) ? step_code : STEP_ZERO;
      res_sstep = (op_r == OP_EDGE2) ? step_code : STEP_ZERO;
    end
    out_data_nxt = {4'b0, res_sstep, res_fstep, res_spos, res_fpos, res_time};
    out_user_nxt = {res_popv, res_drop, res_acc};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      wr_idx_r     <= '0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      if (cmd.finish && is_edge) begin
        first_cnt_r  <= first_cnt_nxt;
        second_cnt_r <= second_cnt_nxt;
      end
      if (push) begin
        wr_idx_r <= wr_inc;
      end
      if (cmd.pop_done) begin
        rd_idx_r <= rd_inc;
      end
      if (cmd.finish || cmd.pop_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_tuser;
      phase_r <= in_tdata[0];
      time_r  <= in_tdata[TIME_W:1];
    end
    if (cmd.finish || cmd.pop_done) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  // ring write port
  always_ff @(posedge clk) begin
    if (push) begin
      time_mem[wr_idx_r] <= time_r;
      pos_mem[wr_idx_r]  <= {second_cnt_nxt, first_cnt_nxt};
      step_mem[wr_idx_r] <= {res_sstep, res_fstep};
    end
  end

  // ring read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_time_r <= time_mem[rd_idx_r];
      rd_pos_r  <= pos_mem[rd_idx_r];
      rd_step_r <= step_mem[rd_idx_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: src/encoder_event_logger_fifo_top.sv
// top level of the timestamped encoder event logger with record ring
// timing: the input transaction is captured, then the execute step loads an edge, no-op or
//   empty pop result into the output register; a pop with data adds the registered ring read
// sequencing: one transaction in flight at a time, set by the controller sequence capture /
//   execute / ring read; the next input is taken while a result waits
// reset: synchronous active-low rst_n clears positions, pointers, logging enable and
//   the output valid; ring contents are not cleared and need no clearing pass
module encoder_event_logger_fifo_top
  import eel_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,   // logging_enable
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // phase_b, event_time, zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,      // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // record_time, first_position, second_position, first_step, second_step, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser      // accepted, dropped, pop_valid
);

  eel_cmd_t  cmd;
  eel_stat_t stat;

  eel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  eel_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // one transaction in flight: ready drops right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a transaction is in flight");

  // a dropped record is always an accepted edge
  a_drop_is_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tuser[0])
    else $error("dropped flag without accepted edge");

  // a result is either an edge or a pop, never both
  a_edge_xor_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[2]))
    else $error("result flagged as both edge and pop");

endmodule
